### rtl/core/cassette_audio_byte_demodulator_defines.svh
// Assertion macros for the cassette audio byte demodulator checker.
// Used by the checker file only; no other dependencies.
`ifndef CASSETTE_AUDIO_BYTE_DEMODULATOR_DEFINES_SVH
`define CASSETTE_AUDIO_BYTE_DEMODULATOR_DEFINES_SVH

// Check a property outside reset; the check is disabled while reset is asserted.
`define CABD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CABD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/cabd_pkg.sv
// Shared types and constants of the cassette audio byte demodulator.
// No dependencies.
`default_nettype none
package cabd_pkg;
    localparam int RING_DEPTH_DEF   = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [14:0] MIN_AMP_RST  = 15'd3000;
    localparam logic [7:0]  SEARCH_RST   = 8'd29;
    localparam logic [7:0]  LONG_THR_RST = 8'd39;
    localparam logic [8:0]  WINDOW_RST   = 9'd105;

    typedef enum logic [1:0] {
        REG_MIN_AMP  = 2'd0,
        REG_SEARCH   = 2'd1,
        REG_LONG_THR = 2'd2,
        REG_WINDOW   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_BYTE = 2'd0,
        ST_NULL = 2'd1,
        ST_END  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CYC_NULL  = 2'd0,
        CYC_SHORT = 2'd1,
        CYC_LONG  = 2'd2
    } t_cyc;

    typedef enum logic [2:0] {
        S_IDLE, S_STORE, S_CHECK, S_RD, S_CMP, S_DECODE
    } t_state;

    typedef struct packed {
        logic [14:0] min_amp;
        logic [7:0]  search_len;
        logic [7:0]  long_thr;
        logic [8:0]  window_len;
    } t_cfg;

    typedef struct packed {
        logic [7:0] byte_value;
        t_status    status;
    } t_res;
endpackage
`default_nettype wire

### rtl/core/cassette_audio_byte_demodulator.sv
// Top level: configuration registers, input queue, engine and result queue.
// Depends on cabd_pkg, cabd_fifo and cabd_back.
//
//   channel  | direction | handshake            | payload
//   input    | in        | push / full          | i_sample, i_end_of_audio
//   result   | out       | pop / empty          | o_byte_value, o_status
//   config   | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// A sample passes idle, store and check; a measurement then walks the ring through
// the single read port in alternating read and compare states (none if search_len
// is zero) and ends in decode. Reset is synchronous and needs no clearing pass.
// A full result queue holds the engine; a busy engine fills the input queue.
`default_nettype none
module cassette_audio_byte_demodulator import cabd_pkg::*; #(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                    i_end_of_audio,
    input  wire logic                    pop,
    output logic                         empty,
    output logic [7:0]                   o_byte_value,
    output logic [1:0]                   o_status,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    t_cfg                    r_cfg;
    t_reg_idx                idx;
    logic                    item_empty, item_pop, item_eoa, res_full, res_push;
    logic [SAMPLE_WIDTH-1:0] item_sample;
    t_res                    res, res_q;

    assign pready = 1'b1;
    assign idx    = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{min_amp: MIN_AMP_RST, search_len: SEARCH_RST,
                       long_thr: LONG_THR_RST, window_len: WINDOW_RST};
        end else if (psel && penable && pwrite && pready) begin
            unique case (idx)
                REG_MIN_AMP:  r_cfg.min_amp    <= pwdata[14:0];
                REG_SEARCH:   r_cfg.search_len <= pwdata[7:0];
                REG_LONG_THR: r_cfg.long_thr   <= pwdata[7:0];
                REG_WINDOW:   r_cfg.window_len <= pwdata[8:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MIN_AMP:  prdata = 32'(r_cfg.min_amp);
            REG_SEARCH:   prdata = 32'(r_cfg.search_len);
            REG_LONG_THR: prdata = 32'(r_cfg.long_thr);
            REG_WINDOW:   prdata = 32'(r_cfg.window_len);
            default:      prdata = '0;
        endcase
    end

    cabd_fifo #(.WIDTH(SAMPLE_WIDTH + 1), .DEPTH(QUEUE_DEPTH)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({i_end_of_audio, i_sample}),
        .o_full  (full),
        .i_pop   (item_pop),
        .o_data  ({item_eoa, item_sample}),
        .o_empty (item_empty)
    );

    cabd_back #(.RING_DEPTH(RING_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item_empty  (item_empty),
        .i_item_sample (item_sample),
        .i_item_eoa    (item_eoa),
        .o_item_pop    (item_pop),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res)
    );

    cabd_fifo #(.WIDTH($bits(t_res)), .DEPTH(QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_byte_value = res_q.byte_value;
    assign o_status     = res_q.status;
endmodule
`default_nettype wire

### rtl/core/cabd_fifo.sv
// Small synchronous queue used on the input and result sides.
// No package dependencies.
`default_nettype none
module cabd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [PW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

### rtl/core/cabd_back.sv
// Measurement engine: sample ring, extreme search, cycle classing, bit decode.
// Depends on cabd_pkg.
`default_nettype none
module cabd_back import cabd_pkg::*; #(
    parameter int RING_DEPTH   = RING_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_item_empty,
    input  wire logic [SAMPLE_WIDTH-1:0] i_item_sample,
    input  wire logic                    i_item_eoa,
    output logic                         o_item_pop,
    input  wire logic                    i_res_full,
    output logic                         o_res_push,
    output t_res                         o_res
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int SW = SAMPLE_WIDTH;
    localparam int TW = ((SW > 16) ? SW : 16) + 2;
    localparam int CW = AW + 9;

    logic [SW-1:0] r_ring [RING_DEPTH];
    logic [SW-1:0] r_rd_q;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_wp, n_wp, r_start, n_start, r_p, n_p, r_found, n_found;
    logic [7:0]           r_i, n_i;
    logic signed [TW-1:0] r_thr, n_thr;
    logic                 r_max, n_max, r_first, n_first, r_fv, n_fv;
    logic [SW-1:0]        r_s, n_s;
    t_cyc                 r_cyc, n_cyc;
    logic [1:0]           r_bph, n_bph;
    logic [2:0]           r_bcnt, n_bcnt;
    logic [6:0]           r_shift, n_shift;

    logic                 mem_we, hit, fv_new, last, have_bit, bit_null, bit_val, b;
    logic [AW-1:0]        ahead, found_new, len, skip;
    logic signed [TW-1:0] q, amp, thr_new;

    assign ahead = r_wp - r_start;
    assign q     = TW'($signed(r_rd_q));
    assign amp   = $signed(TW'(i_cfg.min_amp));
    assign skip  = AW'(i_cfg.window_len[8:2]);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[r_wp] <= r_s;
        end
        r_rd_q <= r_ring[r_p];
    end

    always_ff @(posedge i_clk) begin
        r_p     <= n_p;
        r_found <= n_found;
        r_i     <= n_i;
        r_thr   <= n_thr;
        r_s     <= n_s;
        r_cyc   <= n_cyc;
        r_first <= n_first;
        r_max   <= n_max;
        r_fv    <= n_fv;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_start <= '0;
            r_bph   <= '0;
            r_bcnt  <= '0;
            r_shift <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_start <= n_start;
            r_bph   <= n_bph;
            r_bcnt  <= n_bcnt;
            r_shift <= n_shift;
        end
    end

    always_comb begin
        n_state = r_state;  n_wp = r_wp;    n_start = r_start; n_p = r_p;
        n_found = r_found;  n_i = r_i;      n_thr = r_thr;     n_max = r_max;
        n_first = r_first;  n_fv = r_fv;    n_s = r_s;         n_cyc = r_cyc;
        n_bph = r_bph;      n_bcnt = r_bcnt; n_shift = r_shift;
        mem_we = 1'b0;      o_item_pop = 1'b0; o_res_push = 1'b0;
        o_res = '{byte_value: 8'd0, status: ST_BYTE};
        hit = 1'b0; fv_new = r_fv; found_new = r_found; thr_new = r_thr;
        last = 1'b0; len = '0;
        have_bit = 1'b0; bit_null = 1'b0; bit_val = 1'b0; b = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_item_empty && !i_res_full) begin
                    o_item_pop = 1'b1;
                    if (i_item_eoa) begin
                        o_res_push = 1'b1;
                        o_res.status = ST_END;
                        n_start = r_wp;
                        n_bph = '0;
                        n_bcnt = '0;
                        n_shift = '0;
                    end else begin
                        n_s = i_item_sample;
                        n_state = S_STORE;
                    end
                end
            end
            S_STORE: begin
                if (ahead != AW'(RING_DEPTH - 1)) begin
                    mem_we = 1'b1;
                    n_wp = r_wp + 1'b1;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (CW'(ahead) < CW'(i_cfg.window_len)) begin
                    n_state = S_IDLE;
                end else if (i_cfg.search_len == 8'd0) begin
                    n_start = r_start + skip;
                    n_cyc = CYC_NULL;
                    n_state = S_DECODE;
                end else begin
                    n_p = r_start;
                    n_first = 1'b1;
                    n_max = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_RD;
                if (r_first) begin
                    n_first = 1'b0;
                    n_thr = q - amp;
                    n_p = r_p + 1'b1;
                    n_i = '0;
                    n_fv = 1'b0;
                end else begin
                    hit = r_max ? (q > r_thr) : (q < r_thr);
                    if (hit) begin
                        thr_new = q;
                        found_new = r_p;
                        fv_new = 1'b1;
                    end
                    n_thr = thr_new;
                    n_found = found_new;
                    n_fv = fv_new;
                    n_p = r_p + 1'b1;
                    n_i = r_i + 8'd1;
                    last = (8'(r_i + 8'd1) == i_cfg.search_len);
                    if (last) begin
                        if (!fv_new) begin
                            n_start = r_start + skip;
                            n_cyc = CYC_NULL;
                            n_state = S_DECODE;
                        end else if (!r_max) begin
                            n_thr = thr_new + amp;
                            n_p = found_new;
                            n_i = '0;
                            n_fv = 1'b0;
                            n_max = 1'b1;
                        end else begin
                            len = found_new - r_start;
                            n_start = found_new;
                            n_cyc = ((AW+8)'(len) < (AW+8)'(i_cfg.long_thr)) ?
                                    CYC_SHORT : CYC_LONG;
                            n_state = S_DECODE;
                        end
                    end
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                priority if (r_bph == 2'd0) begin
                    if (r_cyc == CYC_SHORT) begin
                        n_bph = 2'd1;
                    end else begin
                        have_bit = 1'b1;
                        bit_null = 1'b1;
                    end
                end else if (r_bph == 2'd1) begin
                    if (r_cyc == CYC_SHORT) begin
                        n_bph = 2'd2;
                    end else begin
                        have_bit = 1'b1;
                        bit_null = (r_cyc != CYC_LONG);
                    end
                end else begin
                    have_bit = 1'b1;
                    bit_null = (r_cyc != CYC_SHORT);
                    bit_val = 1'b1;
                end
                if (have_bit) begin
                    n_bph = 2'd0;
                    b = bit_null ? 1'b0 : bit_val;
                    if (bit_null && r_bcnt != 3'd7) begin
                        o_res_push = 1'b1;
                        o_res.status = ST_NULL;
                        n_bcnt = '0;
                        n_shift = '0;
                    end else if (r_bcnt == 3'd7) begin
                        o_res_push = 1'b1;
                        o_res.byte_value = {r_shift, b};
                        n_bcnt = '0;
                        n_shift = '0;
                    end else begin
                        n_shift = {r_shift[5:0], b};
                        n_bcnt = r_bcnt + 3'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/cabd_checker.sv
// Port-level checks of the cassette audio byte demodulator, bound to the top.
// Depends on cabd_pkg and cassette_audio_byte_demodulator_defines.svh.
`default_nettype none
`include "cassette_audio_byte_demodulator_defines.svh"
module cabd_checker import cabd_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_byte_value,
    input wire logic [1:0] o_status,
    input wire logic       pready
);
    `CABD_ASSERT(a_status_code, i_clk, i_rst_n, !empty |-> (o_status == ST_BYTE || o_status == ST_NULL || o_status == ST_END), "bad status code")
    `CABD_ASSERT(a_null_zero, i_clk, i_rst_n, (!empty && o_status != ST_BYTE) |-> (o_byte_value == 8'd0), "nonzero byte on non-byte status")
    `CABD_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_byte_value)), "waiting result changed")
    `CABD_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (empty && pready), "results after reset")
endmodule

bind cassette_audio_byte_demodulator cabd_checker u_cabd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_byte_value (o_byte_value),
    .o_status     (o_status),
    .pready       (pready)
);
`default_nettype wire
